// ----- sv/mf3_pkg.sv -----
package mf3_pkg;

  localparam int MAX_WIDTH_DEF = 2048;
  localparam int PIX_W         = 8;
  localparam int ROW_W         = 16;
  localparam int COL_W         = 11;
  localparam int WREG_W        = 12;
  localparam int CFG_W         = 16;
  localparam int WIN_N         = 9;
  localparam int FIFO_DEPTH    = 4;
  localparam int TDATA_W       = 40;

  localparam logic [WREG_W-1:0] WIDTH_RST  = 12'd640;
  localparam logic [ROW_W-1:0]  HEIGHT_RST = 16'd480;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } mf3_reg_e;

  // Per-pixel bookkeeping decided at the front.
  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             has_med;
    logic             border;
    logic             eoi;
  } mf3_meta_t;

  typedef struct packed {
    logic [WIN_N-1:0][PIX_W-1:0] win;
    mf3_meta_t                   meta;
  } mf3_entry_t;

endpackage

// ----- sv/mf3_ram.sv -----
module mf3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/mf3_fifo.sv -----
module mf3_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o  = mem_q[rd_ptr_q];
  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);

endmodule

// ----- sv/mf3_front.sv -----
module mf3_front #(
  parameter int MAX_WIDTH = mf3_pkg::MAX_WIDTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  mf3_pkg::mf3_reg_e           cfg_idx_i,
  input  logic [mf3_pkg::CFG_W-1:0]   cfg_data_i,
  input  logic                        pix_valid_i,
  output logic                        pix_ready_o,
  input  logic [mf3_pkg::PIX_W-1:0]   pix_i,
  output logic                        push_o,
  output mf3_pkg::mf3_entry_t         entry_o,
  input  logic                        full_i
);

  import mf3_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);

  logic [WREG_W-1:0] width_q;
  logic [ROW_W-1:0]  height_q;
  logic [ROW_W-1:0]  row_q;
  logic [CW-1:0]     col_q;
  logic [CW-1:0]     wl;
  logic [ROW_W-1:0]  hl;
  logic              accept;

  // Item held while the line store read completes.
  logic              s1_valid_q, s1_valid_d;
  logic [PIX_W-1:0]  s1_pix_q;
  logic [ROW_W-1:0]  s1_row_q;
  logic [CW-1:0]     s1_col_q;
  logic              s1_med_q, s1_border_q, s1_eoi_q;

  logic [WIN_N-1:0][PIX_W-1:0] win_q, win_d;
  logic [PIX_W-1:0]            top_rd, mid_rd;

  always_comb begin
    if (width_q < 12'd3) begin
      wl = CW'(2);
    end else if (32'(width_q) > MAX_WIDTH) begin
      wl = CW'(MAX_WIDTH - 1);
    end else begin
      wl = CW'(width_q - 12'd1);
    end
    hl = (height_q < 16'd3) ? 16'd2 : height_q - 16'd1;
  end

  assign pix_ready_o = !s1_valid_q || !full_i;
  assign accept      = pix_valid_i && pix_ready_o;
  assign push_o      = s1_valid_q && !full_i;
  assign s1_valid_d  = accept || (s1_valid_q && !push_o);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_WIDTH:  width_q  <= cfg_data_i[WREG_W-1:0];
        REG_HEIGHT: height_q <= cfg_data_i[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  // Any register write starts a new image.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (cfg_we_i) begin
      row_q <= '0;
      col_q <= '0;
    end else if (accept) begin
      if (col_q == wl) begin
        col_q <= '0;
        row_q <= (row_q == hl) ? '0 : row_q + 1'b1;
      end else begin
        col_q <= col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      win_q      <= '0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (push_o) begin
        win_q <= win_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q    <= pix_i;
      s1_row_q    <= row_q;
      s1_col_q    <= col_q;
      s1_med_q    <= (row_q >= 16'd2) && (col_q >= CW'(2));
      s1_border_q <= (row_q == '0) || (row_q == hl) || (col_q == '0) || (col_q == wl);
      s1_eoi_q    <= (row_q == hl) && (col_q == wl);
    end
  end

  mf3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
    .clk_i   (clk_i),
    .we_i    (push_o),
    .waddr_i (s1_col_q),
    .wdata_i (mid_rd),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (top_rd)
  );

  mf3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_lower (
    .clk_i   (clk_i),
    .we_i    (push_o),
    .waddr_i (s1_col_q),
    .wdata_i (s1_pix_q),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (mid_rd)
  );

  // Window rows are entries 0..2, 3..5 and 6..8; the newest column enters on the right.
  always_comb begin
    win_d    = win_q;
    win_d[0] = win_q[1];
    win_d[1] = win_q[2];
    win_d[2] = top_rd;
    win_d[3] = win_q[4];
    win_d[4] = win_q[5];
    win_d[5] = mid_rd;
    win_d[6] = win_q[7];
    win_d[7] = win_q[8];
    win_d[8] = s1_pix_q;
  end

  always_comb begin
    entry_o              = '0;
    entry_o.win          = win_d;
    entry_o.meta.pix     = s1_pix_q;
    entry_o.meta.row     = s1_row_q;
    entry_o.meta.col     = COL_W'(s1_col_q);
    entry_o.meta.has_med = s1_med_q;
    entry_o.meta.border  = s1_border_q;
    entry_o.meta.eoi     = s1_eoi_q;
  end

endmodule

// ----- sv/mf3_back.sv -----
module mf3_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  output logic                          pop_o,
  input  mf3_pkg::mf3_entry_t           entry_i,
  input  logic                          empty_i,
  output logic                          tvalid_o,
  input  logic                          tready_i,
  output logic [mf3_pkg::TDATA_W-1:0]   tdata_o,
  output logic                          tlast_o,
  output logic                          tuser_o
);

  import mf3_pkg::*;

  typedef logic [2:0][PIX_W-1:0] trio_t;

  function automatic logic [PIX_W-1:0] min2(input logic [PIX_W-1:0] a, b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [PIX_W-1:0] max2(input logic [PIX_W-1:0] a, b);
    return (a < b) ? b : a;
  endfunction

  function automatic logic [PIX_W-1:0] med3(input logic [PIX_W-1:0] a, b, c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  // Sorted ascending: entry 0 lowest, entry 2 highest.
  function automatic trio_t sort3(input logic [PIX_W-1:0] a, b, c);
    trio_t r;
    r[0] = min2(min2(a, b), c);
    r[1] = med3(a, b, c);
    r[2] = max2(max2(a, b), c);
    return r;
  endfunction

  logic              a_valid_q;
  trio_t [2:0]       a_rows_q;
  mf3_meta_t         a_meta_q;

  logic              b_valid_q;
  logic [PIX_W-1:0]  b_med_q;
  mf3_meta_t         b_meta_q;
  logic              ph_q, ph_d;

  logic              o_valid_q;
  logic [PIX_W-1:0]  o_pix_q;
  logic [ROW_W-1:0]  o_row_q;
  logic [COL_W-1:0]  o_col_q;
  logic              o_last_q, o_eoi_q;

  logic a_adv, b_take, b_load, b_done, out_free, want_med, want_pix, emit;

  assign out_free = !o_valid_q || tready_i;
  assign want_med = b_meta_q.has_med && !ph_q;
  assign want_pix = b_meta_q.border;
  assign emit     = b_valid_q && out_free && (want_med || want_pix);

  // A median owed to the pixel up and left goes out before the border pixel itself.
  always_comb begin
    if (want_med) begin
      b_done = b_valid_q && out_free && !want_pix;
    end else if (want_pix) begin
      b_done = b_valid_q && out_free;
    end else begin
      b_done = b_valid_q;
    end
  end

  assign b_take = !b_valid_q || b_done;
  assign b_load = a_valid_q && b_take;
  assign a_adv  = !a_valid_q || b_take;
  assign pop_o  = !empty_i && a_adv;

  always_comb begin
    ph_d = ph_q;
    if (b_take) begin
      ph_d = 1'b0;
    end else if (emit && want_med) begin
      ph_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      ph_q      <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      a_valid_q <= pop_o || (a_valid_q && !b_take);
      b_valid_q <= b_load || (b_valid_q && !b_done);
      ph_q      <= ph_d;
      o_valid_q <= emit || (o_valid_q && !tready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      a_rows_q[0] <= sort3(entry_i.win[0], entry_i.win[1], entry_i.win[2]);
      a_rows_q[1] <= sort3(entry_i.win[3], entry_i.win[4], entry_i.win[5]);
      a_rows_q[2] <= sort3(entry_i.win[6], entry_i.win[7], entry_i.win[8]);
      a_meta_q    <= entry_i.meta;
    end
    if (b_load) begin
      b_med_q  <= med3(max2(max2(a_rows_q[0][0], a_rows_q[1][0]), a_rows_q[2][0]),
                       med3(a_rows_q[0][1], a_rows_q[1][1], a_rows_q[2][1]),
                       min2(min2(a_rows_q[0][2], a_rows_q[1][2]), a_rows_q[2][2]));
      b_meta_q <= a_meta_q;
    end
    if (emit) begin
      if (want_med) begin
        o_pix_q  <= b_med_q;
        o_row_q  <= b_meta_q.row - 1'b1;
        o_col_q  <= b_meta_q.col - 1'b1;
        o_last_q <= !want_pix;
        o_eoi_q  <= 1'b0;
      end else begin
        o_pix_q  <= b_meta_q.pix;
        o_row_q  <= b_meta_q.row;
        o_col_q  <= b_meta_q.col;
        o_last_q <= 1'b1;
        o_eoi_q  <= b_meta_q.eoi;
      end
    end
  end

  assign tvalid_o = o_valid_q;
  assign tdata_o  = {(TDATA_W - PIX_W - ROW_W - COL_W)'(0), o_col_q, o_row_q, o_pix_q};
  assign tlast_o  = o_eoi_q;
  assign tuser_o  = o_last_q;

endmodule

// ----- sv/median_filter_3x3_top.sv -----
// Throughput: one pixel per cycle while the output accepts results; results leave at one
// per cycle, so a pixel that yields two results (last row or last column, from the third
// row and column on) holds back the pixels behind it while its second result goes out.
// Path: the first result of a pixel passes the line store read, the queue, the two median
// sorting stages and the output register.
// Reset: asynchronous, active low; counters at row 0, column 0, window zero, width 640,
// height 480. Line stores are not cleared; no clearing pass is needed.
module median_filter_3x3_top #(
  parameter int MAX_WIDTH = mf3_pkg::MAX_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  mf3_pkg::mf3_reg_e             cfg_idx_i,
  input  logic [mf3_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // pixel_in
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [mf3_pkg::TDATA_W-1:0]   m_axis_tdata,  // pixel_out, out_row, out_col, zero pad
  output logic                          m_axis_tlast,  // end_of_image
  output logic                          m_axis_tuser   // last_of_item
);

  import mf3_pkg::*;

  logic       push, pop, full, empty;
  mf3_entry_t push_entry, pop_entry;

  mf3_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .pix_valid_i (s_axis_tvalid),
    .pix_ready_o (s_axis_tready),
    .pix_i       (s_axis_tdata),
    .push_o      (push),
    .entry_o     (push_entry),
    .full_i      (full)
  );

  mf3_fifo #(.WIDTH($bits(mf3_entry_t)), .DEPTH(FIFO_DEPTH)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (pop_entry),
    .empty_o (empty)
  );

  mf3_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .pop_o    (pop),
    .entry_i  (pop_entry),
    .empty_i  (empty),
    .tvalid_o (m_axis_tvalid),
    .tready_i (m_axis_tready),
    .tdata_o  (m_axis_tdata),
    .tlast_o  (m_axis_tlast),
    .tuser_o  (m_axis_tuser)
  );

endmodule

// ----- bench/mf3_result_checker.sv -----
`timescale 1ns / 1ps

module mf3_result_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  mf3_pkg::mf3_reg_e           cfg_idx_i,
  input  logic [mf3_pkg::CFG_W-1:0]   cfg_data_i,
  input  logic                        pix_valid_i,
  input  logic                        pix_ready_i,
  input  logic [7:0]                  pix_data_i,
  input  logic                        res_valid_i,
  input  logic                        res_ready_i,
  input  logic [mf3_pkg::TDATA_W-1:0] res_data_i,
  input  logic                        res_eoi_i,
  input  logic                        res_last_i,
  output int                          mismatches_o,
  output int                          pending_o
);
  import mf3_pkg::*;

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last_of_pixel;
    logic             end_of_image;
  } filtered_pixel_t;

  filtered_pixel_t expected_pixels[$];

  logic [PIX_W-1:0]            upper_line [MAX_WIDTH_DEF];
  logic [PIX_W-1:0]            lower_line [MAX_WIDTH_DEF];
  logic [WIN_N-1:0][PIX_W-1:0] window;
  int unsigned                 row_pos;
  int unsigned                 col_pos;
  int unsigned                 width_reg;
  int unsigned                 height_reg;

  function automatic logic [PIX_W-1:0] median_of_nine(input logic [WIN_N-1:0][PIX_W-1:0] w);
    logic [PIX_W-1:0] v [WIN_N];
    logic [PIX_W-1:0] key;
    int               j;
    for (int i = 0; i < WIN_N; i++) v[i] = w[i];
    for (int i = 1; i < WIN_N; i++) begin
      key = v[i];
      j = i;
      while (j > 0 && v[j-1] > key) begin
        v[j] = v[j-1];
        j--;
      end
      v[j] = key;
    end
    return v[WIN_N/2];
  endfunction

  task automatic flag_mismatch(input string what);
    mismatches_o++;
    if (mismatches_o <= REPORT_LIMIT) $display("[%0t] result mismatch: %s", $realtime, what);
  endtask

  // A pixel at (r, c) closes the window centered on (r-1, c-1) and, on the border,
  // also passes straight through.
  task automatic filter_pixel(input logic [PIX_W-1:0] pix);
    int unsigned      eff_w;
    int unsigned      eff_h;
    int unsigned      idx;
    logic [PIX_W-1:0] top_px;
    logic [PIX_W-1:0] mid_px;
    filtered_pixel_t  res [2];
    int               n;
    eff_w = (width_reg < 3) ? 3 : (width_reg > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : width_reg;
    eff_h = (height_reg < 3) ? 3 : height_reg;
    n = 0;
    idx = col_pos % MAX_WIDTH_DEF;
    top_px = upper_line[idx];
    mid_px = lower_line[idx];
    upper_line[idx] = mid_px;
    lower_line[idx] = pix;
    for (int k = 0; k < WIN_N; k += 3) begin
      window[k]   = window[k+1];
      window[k+1] = window[k+2];
    end
    window[2] = top_px;
    window[5] = mid_px;
    window[8] = pix;
    if (row_pos >= 2 && col_pos >= 2) begin
      res[n] = '0;
      res[n].pix = median_of_nine(window);
      res[n].row = ROW_W'(row_pos - 1);
      res[n].col = COL_W'(col_pos - 1);
      n++;
    end
    if (row_pos == 0 || row_pos == eff_h - 1 || col_pos == 0 || col_pos == eff_w - 1) begin
      res[n] = '0;
      res[n].pix = pix;
      res[n].row = ROW_W'(row_pos);
      res[n].col = COL_W'(col_pos);
      res[n].end_of_image = (row_pos == eff_h - 1) && (col_pos == eff_w - 1);
      n++;
    end
    if (n > 0) res[n-1].last_of_pixel = 1'b1;
    for (int k = 0; k < n; k++) expected_pixels.push_back(res[k]);
    if (col_pos + 1 >= eff_w) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= eff_h) ? 0 : row_pos + 1;
    end else begin
      col_pos++;
    end
  endtask

  task automatic compare_result();
    filtered_pixel_t    want;
    logic [TDATA_W-1:0] want_data;
    if (expected_pixels.size() == 0) begin
      flag_mismatch($sformatf("unexpected transaction tdata=%h tlast=%b tuser=%b",
                              res_data_i, res_eoi_i, res_last_i));
    end else begin
      want = expected_pixels.pop_front();
      want_data = TDATA_W'({want.col, want.row, want.pix});
      if (res_data_i !== want_data || res_last_i !== want.last_of_pixel ||
          res_eoi_i !== want.end_of_image) begin
        flag_mismatch($sformatf(
          "expected pix=%0d row=%0d col=%0d last=%b eoi=%b, got pix=%0d row=%0d col=%0d %s",
          want.pix, want.row, want.col, want.last_of_pixel, want.end_of_image,
          res_data_i[PIX_W-1:0], res_data_i[PIX_W+ROW_W-1:PIX_W],
          res_data_i[PIX_W+ROW_W+COL_W-1:PIX_W+ROW_W],
          $sformatf("last=%b eoi=%b pad=%h", res_last_i, res_eoi_i,
                    res_data_i[TDATA_W-1:PIX_W+ROW_W+COL_W])));
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_WIDTH_DEF; i++) begin
        upper_line[i] = '0;
        lower_line[i] = '0;
      end
      window = '0;
      row_pos = 0;
      col_pos = 0;
      width_reg = WIDTH_RST;
      height_reg = HEIGHT_RST;
      expected_pixels.delete();
      mismatches_o = 0;
    end else begin
      // Results trail their pixel through the pipeline registers, so the result side goes first.
      if (res_valid_i && res_ready_i) compare_result();
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_WIDTH:  width_reg = cfg_data_i[WREG_W-1:0];
          REG_HEIGHT: height_reg = cfg_data_i[ROW_W-1:0];
          default:    ;
        endcase
        row_pos = 0;
        col_pos = 0;
      end
      if (pix_valid_i && pix_ready_i) filter_pixel(pix_data_i);
    end
    pending_o = expected_pixels.size();
  end

endmodule

// ----- bench/tb_median_filter_3x3_top.sv -----
`timescale 1ns / 1ps

module tb_median_filter_3x3_top;
  import mf3_pkg::*;

  localparam int RANDOM_ITEMS = 780;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 12;
  localparam int STALL_LIMIT  = 5000;

  localparam logic [8:0][7:0] CORNER_IMAGE = {
    8'h55, 8'hFE, 8'h01, 8'h7F, 8'h80, 8'hF0, 8'h0F, 8'hFF, 8'h00
  };
  localparam logic [8:0][7:0] WRAP_IMAGE = {
    8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'hCC, 8'h33, 8'hAA
  };

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               cfg_we_i      = 1'b0;
  mf3_reg_e           cfg_idx_i     = REG_WIDTH;
  logic [CFG_W-1:0]   cfg_data_i    = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [7:0]         s_axis_tdata  = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [TDATA_W-1:0] m_axis_tdata;
  logic               m_axis_tlast;
  logic               m_axis_tuser;

  int mismatches;
  int pending;
  int idle_cycles   = 0;
  int holdoffs_asked = 0;
  int holdoffs_done  = 0;
  int cur_width      = WIDTH_RST;
  int cur_height     = HEIGHT_RST;
  int random_sent    = 0;
  int pix_style      = 0;
  bit tx_calm        = 1'b0;
  bit rx_calm        = 1'b0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  median_filter_3x3_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  mf3_result_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .pix_valid_i  (s_axis_tvalid),
    .pix_ready_i  (s_axis_tready),
    .pix_data_i   (s_axis_tdata),
    .res_valid_i  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_data_i   (m_axis_tdata),
    .res_eoi_i    (m_axis_tlast),
    .res_last_i   (m_axis_tuser),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  function automatic int draw_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] next_pixel();
    case (pix_style)
      0: return 8'($urandom_range(0, 255));
      // Mostly saturated values, the case a median filter exists for.
      1: return ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) :
                ($urandom_range(0, 1) ? 8'hFF : 8'h00);
      default: return 8'($urandom_range(96, 160));
    endcase
  endfunction

  function automatic int pixels_per_image();
    int w;
    int h;
    w = (cur_width < 3) ? 3 : (cur_width > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : cur_width;
    h = (cur_height < 3) ? 3 : cur_height;
    return w * h;
  endfunction

  task automatic send_pixel(input logic [7:0] value);
    int pause;
    pause = tx_calm ? 0 : draw_gap();
    if (pause > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (pause) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic wait_until_drained();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input mf3_reg_e idx, input int value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= CFG_W'(value);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    if (idx == REG_WIDTH) cur_width = value;
    else cur_height = value;
  endtask

  task automatic resize(input int w, input int h);
    wait_until_drained();
    if ($urandom_range(0, 1)) begin
      write_reg(REG_WIDTH, w);
      write_reg(REG_HEIGHT, h);
    end else begin
      write_reg(REG_HEIGHT, h);
      write_reg(REG_WIDTH, w);
    end
  endtask

  task automatic send_run(input int count);
    int pause_at;
    pause_at = ($urandom_range(0, 4) == 0) ? $urandom_range(0, count - 1) : -1;
    for (int i = 0; i < count; i++) begin
      if (i == pause_at) wait_until_drained();
      send_pixel(next_pixel());
    end
    random_sent += count;
  endtask

  // Receiver: random back-pressure, calm stretches, and one long hold-off on request.
  initial begin : result_sink
    int stall_left;
    int rx_cycles;
    stall_left = 0;
    rx_cycles = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      rx_cycles++;
      if (rx_cycles % 200 == 0) rx_calm = ($urandom_range(0, 3) == 0);
      if (holdoffs_asked != holdoffs_done) begin
        holdoffs_done++;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
      end else if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
        if (!rx_calm && $urandom_range(0, 2) == 0) stall_left = draw_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : pixel_source
    int kind;
    int w;
    int h;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset size first: a few first-row pixels that only pass through.
    tx_calm = 1'b1;
    send_pixel(8'h00);
    send_pixel(8'hFF);
    send_pixel(8'h5A);
    send_pixel(8'hA5);

    // Undersized registers clamp to the smallest 3x3 image, which has one interior pixel.
    resize(0, 2);
    for (int i = 0; i < 9; i++) send_pixel(CORNER_IMAGE[i]);
    // Second image right after the counters wrap, with a full drain in the middle.
    for (int i = 0; i < 9; i++) begin
      if (i == 4) wait_until_drained();
      send_pixel(WRAP_IMAGE[i]);
    end

    // Fill the block against a receiver that has stopped.
    pix_style = 0;
    resize(12, 30);
    holdoffs_asked++;
    send_run(pixels_per_image());

    while (random_sent < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 9);
      tx_calm = ($urandom_range(0, 3) == 0);
      pix_style = $urandom_range(0, 2);
      if (kind <= 5) begin
        w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 10);
        h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 6);
        resize(w, h);
        send_run(pixels_per_image() * $urandom_range(1, 3));
      end else if (kind <= 7) begin
        resize($urandom_range(11, 64), $urandom_range(3, 5));
        send_run(pixels_per_image());
      end else if (kind == 8) begin
        // A write in the middle of an image restarts it.
        w = $urandom_range(0, 20);
        h = ($urandom_range(0, 3) == 0) ? 65535 : $urandom_range(3, 65535);
        wait_until_drained();
        case ($urandom_range(0, 2))
          0: write_reg(REG_WIDTH, w);
          1: write_reg(REG_HEIGHT, h);
          default: begin
            write_reg(REG_WIDTH, w);
            write_reg(REG_HEIGHT, h);
          end
        endcase
        send_run($urandom_range(1, 80));
      end else begin
        send_run($urandom_range(1, 40));
      end
    end

    // Oversized width register, only the start of its first row.
    tx_calm = 1'b1;
    pix_style = 0;
    resize(4095, 3);
    send_run(60);

    // Tallest setting, only the first rows of it.
    resize(3, 65535);
    send_run(40);

    wait_until_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/mf3_pkg.sv
sv/mf3_ram.sv
sv/mf3_fifo.sv
sv/mf3_front.sv
sv/mf3_back.sv
sv/median_filter_3x3_top.sv
bench/mf3_result_checker.sv
bench/tb_median_filter_3x3_top.sv
